// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only while out of reset, sampled on clk
`define CHK_RST(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CHK_ANY(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_RST(lbl, prop, msg)
`define CHK_ANY(lbl, prop, msg)
`endif
`endif

// File: rtl/rbdm_pkg.sv
// ----------------------------------------------------------------------------
// rbdm_pkg
// Types, register codes, gray weights and Bayer threshold tables.
// ----------------------------------------------------------------------------
package rbdm_pkg;

  localparam int CFG_DATA_W = 11;

  typedef enum logic [1:0] {
    REG_DITHER_MODE     = 2'd0,
    REG_FIXED_THRESHOLD = 2'd1,
    REG_LINE_WIDTH      = 2'd2,
    REG_LINE_COUNT      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_FIXED    = 3'd0,
    MODE_BAYER2   = 3'd1,
    MODE_BAYER3   = 3'd2,
    MODE_BAYER4   = 3'd3,
    MODE_BAYER8   = 3'd4,
    MODE_BAYER16  = 3'd5
  } dither_mode_t;

  localparam logic [2:0]  RST_DITHER_MODE     = 3'd3;
  localparam logic [7:0]  RST_FIXED_THRESHOLD = 8'd140;
  localparam logic [10:0] RST_LINE_WIDTH      = 11'd400;
  localparam logic [10:0] RST_LINE_COUNT      = 11'd240;

  // Q0.16 luma weights
  localparam logic [16:0] GRAY_WR = 17'd19595;
  localparam logic [16:0] GRAY_WG = 17'd38470;
  localparam logic [16:0] GRAY_WB = 17'd7471;
  localparam logic [8:0]  GRAY_MAX = 9'd255;

  localparam logic [7:0] MAT2 [0:3] = '{8'd51, 8'd206, 8'd153, 8'd102};

  localparam logic [7:0] MAT3 [0:8] = '{
    8'd75, 8'd150, 8'd225, 8'd50, 8'd125, 8'd200, 8'd25, 8'd100, 8'd175
  };

  localparam logic [7:0] MAT4 [0:15] = '{
    8'd15,  8'd195, 8'd60,  8'd240, 8'd135, 8'd75,  8'd180, 8'd120,
    8'd45,  8'd225, 8'd30,  8'd210, 8'd165, 8'd105, 8'd150, 8'd90
  };

  localparam logic [7:0] MAT8 [0:63] = '{
    8'd0,   8'd128, 8'd32,  8'd160, 8'd8,   8'd136, 8'd40,  8'd168,
    8'd192, 8'd64,  8'd224, 8'd96,  8'd200, 8'd72,  8'd232, 8'd104,
    8'd48,  8'd176, 8'd16,  8'd144, 8'd56,  8'd184, 8'd24,  8'd152,
    8'd240, 8'd112, 8'd208, 8'd80,  8'd248, 8'd120, 8'd216, 8'd88,
    8'd12,  8'd140, 8'd44,  8'd172, 8'd4,   8'd132, 8'd36,  8'd164,
    8'd204, 8'd76,  8'd236, 8'd108, 8'd196, 8'd68,  8'd228, 8'd100,
    8'd60,  8'd188, 8'd28,  8'd156, 8'd52,  8'd180, 8'd20,  8'd148,
    8'd252, 8'd124, 8'd220, 8'd92,  8'd244, 8'd116, 8'd212, 8'd84
  };

  localparam logic [7:0] MAT16 [0:255] = '{
    8'd0,   8'd191, 8'd48,  8'd239, 8'd12,  8'd203, 8'd60,  8'd251,
    8'd3,   8'd194, 8'd51,  8'd242, 8'd15,  8'd206, 8'd63,  8'd254,
    8'd127, 8'd64,  8'd175, 8'd112, 8'd139, 8'd76,  8'd187, 8'd124,
    8'd130, 8'd67,  8'd178, 8'd115, 8'd142, 8'd79,  8'd190, 8'd127,
    8'd32,  8'd223, 8'd16,  8'd207, 8'd44,  8'd235, 8'd28,  8'd219,
    8'd35,  8'd226, 8'd19,  8'd210, 8'd47,  8'd238, 8'd31,  8'd222,
    8'd159, 8'd96,  8'd143, 8'd80,  8'd171, 8'd108, 8'd155, 8'd92,
    8'd162, 8'd99,  8'd146, 8'd83,  8'd174, 8'd111, 8'd158, 8'd95,
    8'd8,   8'd199, 8'd56,  8'd247, 8'd4,   8'd195, 8'd52,  8'd243,
    8'd11,  8'd202, 8'd59,  8'd250, 8'd7,   8'd198, 8'd55,  8'd246,
    8'd135, 8'd72,  8'd183, 8'd120, 8'd131, 8'd68,  8'd179, 8'd116,
    8'd138, 8'd75,  8'd186, 8'd123, 8'd134, 8'd71,  8'd182, 8'd119,
    8'd40,  8'd231, 8'd24,  8'd215, 8'd36,  8'd227, 8'd20,  8'd211,
    8'd43,  8'd234, 8'd27,  8'd218, 8'd39,  8'd230, 8'd23,  8'd214,
    8'd167, 8'd104, 8'd151, 8'd88,  8'd163, 8'd100, 8'd147, 8'd84,
    8'd170, 8'd107, 8'd154, 8'd91,  8'd166, 8'd103, 8'd150, 8'd87,
    8'd2,   8'd193, 8'd50,  8'd241, 8'd14,  8'd205, 8'd62,  8'd253,
    8'd1,   8'd192, 8'd49,  8'd240, 8'd13,  8'd204, 8'd61,  8'd252,
    8'd129, 8'd66,  8'd177, 8'd114, 8'd141, 8'd78,  8'd189, 8'd126,
    8'd128, 8'd65,  8'd176, 8'd113, 8'd140, 8'd77,  8'd188, 8'd125,
    8'd34,  8'd225, 8'd18,  8'd209, 8'd46,  8'd237, 8'd30,  8'd221,
    8'd33,  8'd224, 8'd17,  8'd208, 8'd45,  8'd236, 8'd29,  8'd220,
    8'd161, 8'd98,  8'd145, 8'd82,  8'd173, 8'd110, 8'd157, 8'd94,
    8'd160, 8'd97,  8'd144, 8'd81,  8'd172, 8'd109, 8'd156, 8'd93,
    8'd10,  8'd201, 8'd58,  8'd249, 8'd6,   8'd197, 8'd54,  8'd245,
    8'd9,   8'd200, 8'd57,  8'd248, 8'd5,   8'd196, 8'd53,  8'd244,
    8'd137, 8'd74,  8'd185, 8'd122, 8'd133, 8'd70,  8'd181, 8'd118,
    8'd136, 8'd73,  8'd184, 8'd121, 8'd132, 8'd69,  8'd180, 8'd117,
    8'd42,  8'd233, 8'd26,  8'd217, 8'd38,  8'd229, 8'd22,  8'd213,
    8'd41,  8'd232, 8'd25,  8'd216, 8'd37,  8'd228, 8'd21,  8'd212,
    8'd169, 8'd106, 8'd153, 8'd90,  8'd165, 8'd102, 8'd149, 8'd86,
    8'd168, 8'd105, 8'd152, 8'd89,  8'd164, 8'd101, 8'd148, 8'd85
  };

endpackage

// File: rtl/rgb565_bayer_dither_to_mono_top.sv
// ----------------------------------------------------------------------------
// rgb565_bayer_dither_to_mono_top
// RGB565 pixel stream to 1-bit monochrome with ordered (Bayer) dithering.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock unless in_stall is high and returns one
// result beat per pixel: the dithered bit, the linear pixel index and a
// store write request raised only when the pixel changed since the previous
// frame and the new bit differs from the stored one. Pixels pass the input
// register, then the result register, with gray conversion, threshold lookup
// and the row-times-width index multiply between them; sustained rate is one
// pixel per cycle while out_stall is low. The column/row position advances on
// each accepted beat. Configuration writes are taken at any time (cfg_ready is
// always high) but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb565_bayer_dither_to_mono_top #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int MAX_LINES      = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [rbdm_pkg::CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_new_pixel,
  input  logic [15:0]                   in_prev_pixel,
  input  logic                          in_stored_bit,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_write_enable,
  output logic                          out_mono_bit,
  output logic [19:0]                   out_pixel_index
);

  localparam int CW   = $clog2(MAX_LINE_WIDTH);      // column counter
  localparam int RW   = $clog2(MAX_LINES);           // row counter
  localparam int WW   = $clog2(MAX_LINE_WIDTH + 1);  // clamped width
  localparam int HW   = $clog2(MAX_LINES + 1);       // clamped line count
  localparam int DW   = rbdm_pkg::CFG_DATA_W;
  localparam int CMPW = ((WW > DW) ? WW : DW) > HW ? ((WW > DW) ? WW : DW) : HW;
  localparam int IDXW = RW + WW + 1;

  // ---------------- configuration registers ----------------
  rbdm_pkg::dither_mode_t mode_r;
  logic [7:0]             fixed_thr_r;
  logic [DW-1:0]          line_width_r;
  logic [DW-1:0]          line_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= rbdm_pkg::dither_mode_t'(rbdm_pkg::RST_DITHER_MODE);
      fixed_thr_r  <= rbdm_pkg::RST_FIXED_THRESHOLD;
      line_width_r <= rbdm_pkg::RST_LINE_WIDTH;
      line_count_r <= rbdm_pkg::RST_LINE_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rbdm_pkg::cfg_reg_t'(cfg_index))
        rbdm_pkg::REG_DITHER_MODE:     mode_r <= rbdm_pkg::dither_mode_t'(cfg_data[2:0]);
        rbdm_pkg::REG_FIXED_THRESHOLD: fixed_thr_r <= cfg_data[7:0];
        rbdm_pkg::REG_LINE_WIDTH:      line_width_r <= cfg_data;
        rbdm_pkg::REG_LINE_COUNT:      line_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as 1, anything above the maximum saturates
  logic [WW-1:0] width_eff;
  logic [HW-1:0] lines_eff;

  always_comb begin
    if (line_width_r == '0) begin
      width_eff = WW'(1);
    end else if (CMPW'(line_width_r) > CMPW'(MAX_LINE_WIDTH)) begin
      width_eff = WW'(MAX_LINE_WIDTH);
    end else begin
      width_eff = WW'(CMPW'(line_width_r));
    end
    if (line_count_r == '0) begin
      lines_eff = HW'(1);
    end else if (CMPW'(line_count_r) > CMPW'(MAX_LINES)) begin
      lines_eff = HW'(MAX_LINES);
    end else begin
      lines_eff = HW'(CMPW'(line_count_r));
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_free, in_fire, s1_move;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- position counters ----------------
  // mod-3 shadows avoid a divide for the 3x3 matrix
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [1:0]    col3_r, col3_nxt, row3_r, row3_nxt;
  logic          col_wrap, row_wrap;

  assign col_wrap = (WW'(col_r) + WW'(1)) >= width_eff;
  assign row_wrap = (HW'(row_r) + HW'(1)) >= lines_eff;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    col3_nxt = col3_r;
    row3_nxt = row3_r;
    if (in_fire) begin
      if (col_wrap) begin
        col_nxt  = '0;
        col3_nxt = 2'd0;
        if (row_wrap) begin
          row_nxt  = '0;
          row3_nxt = 2'd0;
        end else begin
          row_nxt  = row_r + RW'(1);
          row3_nxt = (row3_r == 2'd2) ? 2'd0 : row3_r + 2'd1;
        end
      end else begin
        col_nxt  = col_r + CW'(1);
        col3_nxt = (col3_r == 2'd2) ? 2'd0 : col3_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      col3_r <= 2'd0;
      row3_r <= 2'd0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      col3_r <= col3_nxt;
      row3_r <= row3_nxt;
    end
  end

  // ---------------- input register ----------------
  logic [15:0]   s1_new_r, s1_prev_r;
  logic          s1_sb_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic [1:0]    s1_col3_r, s1_row3_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_new_r  <= in_new_pixel;
      s1_prev_r <= in_prev_pixel;
      s1_sb_r   <= in_stored_bit;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_col3_r <= col3_r;
      s1_row3_r <= row3_r;
    end
  end

  // ---------------- gray, threshold, index ----------------
  logic [7:0]  r8, g8, b8;
  logic [24:0] gray_sum;
  logic [8:0]  gray_full;
  logic [7:0]  gray;
  logic [7:0]  thr;
  logic [3:0]  idx3;
  logic        bit_w, we_w;
  logic [IDXW-1:0]    idx_full;
  logic [IDXW+19:0]   idx_ext;

  assign r8 = {s1_new_r[15:11], s1_new_r[15:13]};
  assign g8 = {s1_new_r[10:5], s1_new_r[10:9]};
  assign b8 = {s1_new_r[4:0], s1_new_r[4:2]};

  assign gray_sum = 25'(rbdm_pkg::GRAY_WR) * 25'(r8)
                  + 25'(rbdm_pkg::GRAY_WG) * 25'(g8)
                  + 25'(rbdm_pkg::GRAY_WB) * 25'(b8);
  assign gray_full = gray_sum[24:16];
  assign gray = (gray_full > rbdm_pkg::GRAY_MAX) ? 8'hFF : gray_full[7:0];

  assign idx3 = 4'(s1_row3_r) * 4'd3 + 4'(s1_col3_r);

  always_comb begin
    case (mode_r)
      rbdm_pkg::MODE_BAYER2:  thr = rbdm_pkg::MAT2[{s1_row_r[0], s1_col_r[0]}];
      rbdm_pkg::MODE_BAYER3:  thr = rbdm_pkg::MAT3[idx3];
      rbdm_pkg::MODE_BAYER4:  thr = rbdm_pkg::MAT4[{s1_row_r[1:0], s1_col_r[1:0]}];
      rbdm_pkg::MODE_BAYER8:  thr = rbdm_pkg::MAT8[{s1_row_r[2:0], s1_col_r[2:0]}];
      rbdm_pkg::MODE_BAYER16: thr = rbdm_pkg::MAT16[{s1_row_r[3:0], s1_col_r[3:0]}];
      default:                thr = fixed_thr_r;  // fixed mode and unused codes
    endcase
  end

  assign bit_w = (gray >= thr);
  assign we_w  = (s1_new_r != s1_prev_r) && (bit_w != s1_sb_r);

  assign idx_full = IDXW'(s1_row_r) * IDXW'(width_eff) + IDXW'(s1_col_r);
  assign idx_ext  = {20'd0, idx_full};

  // ---------------- result register ----------------
  logic        we_r, bit_r;
  logic [19:0] pix_idx_r;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      we_r      <= we_w;
      bit_r     <= bit_w;
      pix_idx_r <= idx_ext[19:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_mono_bit     = bit_r;
  assign out_pixel_index  = pix_idx_r;

  // ---------------- checks ----------------
  `CHK_ANY(a_rst_clears_out, !rst_n |=> !out_valid_r, "result valid survived reset")
  `CHK_RST(a_full_blocks_in, (s1_valid_r && out_valid_r && out_stall) |-> in_stall, "input taken while pipe full")
  `CHK_RST(a_mod3_range, (col3_r != 2'd3) && (row3_r != 2'd3), "mod-3 shadow counter out of range")
  `CHK_RST(a_col_step, (in_fire && !col_wrap) |=> (col_r == $past(col_r) + CW'(1)), "column did not advance")
  `CHK_RST(a_col3_wrap, (in_fire && col_wrap) |=> (col3_r == 2'd0), "mod-3 column not cleared on wrap")

endmodule
